### rtl/ipcsum_pkg.sv
// Shared constants, types and helper function of the IPv4 TCP/UDP checksum stream.
`timescale 1ns / 1ps
`default_nettype none

package ipcsum_pkg;

   localparam int DEF_MAX_FRAME_BYTES = 16384;

   // Frame offsets of the IPv4 header fields.
   localparam int IP_START     = 14;
   localparam int OFS_TLEN_HI  = 16;
   localparam int OFS_TLEN_LO  = 17;
   localparam int OFS_PROTO    = 23;
   localparam int OFS_IPCK_HI  = 24;
   localparam int OFS_IPCK_LO  = 25;
   localparam int OFS_ADDR_LO  = 26;
   localparam int OFS_ADDR_END = 34;

   // Offsets inside the transport header.
   localparam int UDP_LEN_HI = 4;
   localparam int UDP_LEN_LO = 5;
   localparam int UDP_CK_HI  = 6;
   localparam int UDP_CK_LO  = 7;
   localparam int TCP_CK_HI  = 16;
   localparam int TCP_CK_LO  = 17;
   localparam int UDP_MIN    = 8;
   localparam int MIN_IHL    = 5;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_TCP   = 2'd1;
   localparam logic [1:0] KIND_UDP   = 2'd2;

   // Width that holds a frame offset plus a transport start plus a UDP length.
   localparam int CMP_W = 18;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] ip_sum;
      logic [15:0] l4_sum;
      logic [15:0] l4_len;
      logic        len_short;
   } fin_type;

   // One's complement 16-bit add with end-around carry.
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'b0, s[16]};
   endfunction

endpackage

`default_nettype wire

### rtl/ipcsum_accum.sv
// Per-byte header parser and running one's complement sums for one frame.
`timescale 1ns / 1ps
`default_nettype none

module ipcsum_accum #(
   parameter int MAX_FRAME_BYTES = ipcsum_pkg::DEF_MAX_FRAME_BYTES
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          frame_byte,
   input  wire logic                last_byte,
   output ipcsum_pkg::fin_type      fin_rec
);

   localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int CMP_W = ipcsum_pkg::CMP_W;

   logic [OFF_W-1:0] off_ff, off_in, off_upd;
   logic [3:0]       hw_ff, hw_in, hw_n, hw_upd;
   logic [7:0]       pr_ff, pr_in, pr_n, pr_upd;
   logic [15:0]      tl_ff, tl_in, tl_n, tl_upd;
   logic [15:0]      ul_ff, ul_in, ul_n, ul_upd;
   logic [15:0]      ips_ff, ips_in, ips_n, ips_upd;
   logic [15:0]      l4s_ff, l4s_in, l4s_n, l4s_upd;

   logic             taking;
   logic [5:0]       hl, hl_upd;
   logic [6:0]       l4_start, l4_start_upd;
   logic [15:0]      word;
   logic             ip_add, addr_add, in_l4, in_span, zero_fld, l4_add;
   logic [1:0]       kind_n, kind_upd, kind_fin;
   logic [OFF_W-1:0] rel;
   logic [15:0]      limit_n, limit_upd;

   function automatic logic [1:0] kind_of(input logic [3:0] hw, input logic [7:0] pr);
      logic [1:0] k;
      if (hw < 4'(ipcsum_pkg::MIN_IHL)) begin
         k = ipcsum_pkg::KIND_OTHER;
      end else if (pr == ipcsum_pkg::PROTO_TCP) begin
         k = ipcsum_pkg::KIND_TCP;
      end else if (pr == ipcsum_pkg::PROTO_UDP) begin
         k = ipcsum_pkg::KIND_UDP;
      end else begin
         k = ipcsum_pkg::KIND_OTHER;
      end
      return k;
   endfunction

   always_comb begin
      taking = off_ff < OFF_W'(MAX_FRAME_BYTES);

      hw_n = (off_ff == OFF_W'(ipcsum_pkg::IP_START)) ? frame_byte[3:0] : hw_ff;
      tl_n = tl_ff;
      if (off_ff == OFF_W'(ipcsum_pkg::OFS_TLEN_HI)) begin
         tl_n = {frame_byte, tl_ff[7:0]};
      end
      if (off_ff == OFF_W'(ipcsum_pkg::OFS_TLEN_LO)) begin
         tl_n = {tl_ff[15:8], frame_byte};
      end
      pr_n = (off_ff == OFF_W'(ipcsum_pkg::OFS_PROTO)) ? frame_byte : pr_ff;

      hl       = {hw_n, 2'b00};
      l4_start = 7'(ipcsum_pkg::IP_START) + {1'b0, hl};
      word     = off_ff[0] ? {8'h00, frame_byte} : {frame_byte, 8'h00};

      ip_add = (off_ff >= OFF_W'(ipcsum_pkg::IP_START)) && (off_ff < OFF_W'(l4_start)) &&
               (off_ff != OFF_W'(ipcsum_pkg::OFS_IPCK_HI)) &&
               (off_ff != OFF_W'(ipcsum_pkg::OFS_IPCK_LO));
      addr_add = (off_ff >= OFF_W'(ipcsum_pkg::OFS_ADDR_LO)) &&
                 (off_ff < OFF_W'(ipcsum_pkg::OFS_ADDR_END));

      kind_n = kind_of(hw_n, pr_n);
      in_l4  = (kind_n != ipcsum_pkg::KIND_OTHER) && (off_ff >= OFF_W'(l4_start));
      rel    = off_ff - OFF_W'(l4_start);

      ul_n = ul_ff;
      if (in_l4 && rel == OFF_W'(ipcsum_pkg::UDP_LEN_HI)) begin
         ul_n = {frame_byte, ul_ff[7:0]};
      end
      if (in_l4 && rel == OFF_W'(ipcsum_pkg::UDP_LEN_LO)) begin
         ul_n = {ul_ff[15:8], frame_byte};
      end
      limit_n = (ul_n < 16'(ipcsum_pkg::UDP_MIN)) ? 16'(ipcsum_pkg::UDP_MIN) : ul_n;

      if (kind_n == ipcsum_pkg::KIND_TCP) begin
         zero_fld = (rel == OFF_W'(ipcsum_pkg::TCP_CK_HI)) ||
                    (rel == OFF_W'(ipcsum_pkg::TCP_CK_LO));
         in_span  = 1'b1;
      end else begin
         zero_fld = (rel == OFF_W'(ipcsum_pkg::UDP_CK_HI)) ||
                    (rel == OFF_W'(ipcsum_pkg::UDP_CK_LO));
         in_span  = CMP_W'(rel) < CMP_W'(limit_n);
      end
      l4_add = addr_add || (in_l4 && in_span && !zero_fld);

      ips_n = ip_add ? ipcsum_pkg::oc_add(ips_ff, word) : ips_ff;
      l4s_n = l4_add ? ipcsum_pkg::oc_add(l4s_ff, word) : l4s_ff;

      off_upd = taking ? OFF_W'(off_ff + 1'b1) : off_ff;
      hw_upd  = taking ? hw_n  : hw_ff;
      pr_upd  = taking ? pr_n  : pr_ff;
      tl_upd  = taking ? tl_n  : tl_ff;
      ul_upd  = taking ? ul_n  : ul_ff;
      ips_upd = taking ? ips_n : ips_ff;
      l4s_upd = taking ? l4s_n : l4s_ff;

      hl_upd       = {hw_upd, 2'b00};
      l4_start_upd = 7'(ipcsum_pkg::IP_START) + {1'b0, hl_upd};
      limit_upd    = (ul_upd < 16'(ipcsum_pkg::UDP_MIN)) ? 16'(ipcsum_pkg::UDP_MIN) : ul_upd;
      kind_upd     = kind_of(hw_upd, pr_upd);
      kind_fin     = (CMP_W'(off_upd) < CMP_W'(l4_start_upd)) ? ipcsum_pkg::KIND_OTHER
                                                                : kind_upd;

      fin_rec.kind      = kind_fin;
      fin_rec.ip_sum    = ips_upd;
      fin_rec.l4_sum    = l4s_upd;
      fin_rec.l4_len    = (kind_fin == ipcsum_pkg::KIND_TCP) ? tl_upd - {10'b0, hl_upd}
                                                             : ul_upd;
      fin_rec.len_short = (kind_fin == ipcsum_pkg::KIND_UDP) &&
                          (CMP_W'(off_upd) < CMP_W'(l4_start_upd) + CMP_W'(limit_upd));

      off_in = off_ff;
      hw_in  = hw_ff;
      pr_in  = pr_ff;
      tl_in  = tl_ff;
      ul_in  = ul_ff;
      ips_in = ips_ff;
      l4s_in = l4s_ff;
      if (step) begin
         if (last_byte) begin
            off_in = '0;
            hw_in  = '0;
            pr_in  = '0;
            tl_in  = '0;
            ul_in  = '0;
            ips_in = '0;
            l4s_in = '0;
         end else begin
            off_in = off_upd;
            hw_in  = hw_upd;
            pr_in  = pr_upd;
            tl_in  = tl_upd;
            ul_in  = ul_upd;
            ips_in = ips_upd;
            l4s_in = l4s_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= '0;
         hw_ff  <= '0;
         pr_ff  <= '0;
         tl_ff  <= '0;
         ul_ff  <= '0;
         ips_ff <= '0;
         l4s_ff <= '0;
      end else begin
         off_ff <= off_in;
         hw_ff  <= hw_in;
         pr_ff  <= pr_in;
         tl_ff  <= tl_in;
         ul_ff  <= ul_in;
         ips_ff <= ips_in;
         l4s_ff <= l4s_in;
      end
   end

endmodule

`default_nettype wire

### rtl/ipcsum_final.sv
// Frame-end register, pseudo header completion and result output register.
`timescale 1ns / 1ps
`default_nettype none

module ipcsum_final (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fin_load,
   input  wire ipcsum_pkg::fin_type fin_rec,
   output logic                     fin_free,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [39:0]              rsp_tdata,
   output logic [1:0]               rsp_tuser
);

   logic                fin_valid_ff, fin_valid_in;
   ipcsum_pkg::fin_type fin_ff, fin_in;
   logic                out_valid_ff, out_valid_in;
   logic [1:0]          kind_ff, kind_in;
   logic [15:0]         ipc_ff, ipc_in;
   logic [15:0]         l4c_ff, l4c_in;
   logic                short_ff, short_in;

   logic                out_free;
   logic [15:0]         s1, s2;
   logic [7:0]          proto;

   always_comb begin
      out_free = !out_valid_ff || rsp_tready;
      fin_free = !fin_valid_ff || out_free;

      proto = (fin_ff.kind == ipcsum_pkg::KIND_TCP) ? ipcsum_pkg::PROTO_TCP
                                                     : ipcsum_pkg::PROTO_UDP;
      s1 = ipcsum_pkg::oc_add(fin_ff.l4_sum, {8'h00, proto});
      s2 = ipcsum_pkg::oc_add(s1, fin_ff.l4_len);

      fin_in       = fin_load ? fin_rec : fin_ff;
      fin_valid_in = fin_load ? 1'b1 : (fin_valid_ff && !out_free);

      out_valid_in = out_free ? fin_valid_ff : out_valid_ff;
      kind_in      = kind_ff;
      ipc_in       = ipc_ff;
      l4c_in       = l4c_ff;
      short_in     = short_ff;
      if (out_free && fin_valid_ff) begin
         kind_in  = fin_ff.kind;
         ipc_in   = ~fin_ff.ip_sum;
         l4c_in   = (fin_ff.kind == ipcsum_pkg::KIND_OTHER) ? 16'h0000 : ~s2;
         short_in = fin_ff.len_short;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff   <= fin_in;
      kind_ff  <= kind_in;
      ipc_ff   <= ipc_in;
      l4c_ff   <= l4c_in;
      short_ff <= short_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, short_ff, l4c_ff, ipc_ff};
   assign rsp_tuser  = kind_ff;

endmodule

`default_nettype wire

### rtl/ipv4_tcp_udp_checksum_stream.sv
// Top level of the IPv4 header and TCP/UDP checksum engine for a byte stream.
//
//   Group   Direction  Word                               Per
//   req_*   in         tdata[7:0] frame byte, tlast end   one frame byte
//   rsp_*   out        tdata ip/l4 checksums, short flag  one result per frame
//                      tuser packet kind
//
// A byte passes the input register, and its frame's sums then pass the frame-end register
// and the output register before the result is shown on rsp_*.
// One byte is taken every cycle; the input stalls only when a frame end meets
// both the frame-end register and an output word that is not taken yet.
// Reset is synchronous and returns all parsing state and running sums to zero.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_tcp_udp_checksum_stream #(
   parameter int MAX_FRAME_BYTES = ipcsum_pkg::DEF_MAX_FRAME_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [15:0] ip_checksum, [31:16] l4_checksum,
                                         // [32] length_short, [39:33] zero
   output logic [1:0]       rsp_tuser    // [1:0] packet_kind
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                in_last_ff, in_last_in;
   logic                in_free, in_step, fin_free;
   ipcsum_pkg::fin_type fin_rec;

   always_comb begin
      in_free     = !in_valid_ff || !in_last_ff || fin_free;
      in_step     = in_valid_ff && in_free;
      req_tready  = in_free;
      in_valid_in = in_free ? req_tvalid : in_valid_ff;
      in_byte_in  = (in_free && req_tvalid) ? req_tdata : in_byte_ff;
      in_last_in  = (in_free && req_tvalid) ? req_tlast : in_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   ipcsum_accum #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .step       (in_step),
      .frame_byte (in_byte_ff),
      .last_byte  (in_last_ff),
      .fin_rec    (fin_rec)
   );

   ipcsum_final u_final (
      .clock      (clock),
      .reset      (reset),
      .fin_load   (in_step && in_last_ff),
      .fin_rec    (fin_rec),
      .fin_free   (fin_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
